FILE: hw/rtl/jst_pkg.sv
// jst_pkg: shared types and constants for the JSON stream tokenizer.
// Holds character codes, token kinds, status codes, scan/expect encodings and result struct.
// No dependencies.
package jst_pkg;

	// Character codes
	localparam logic [7:0] CH_LCUB  = 8'h7B;
	localparam logic [7:0] CH_RCUB  = 8'h7D;
	localparam logic [7:0] CH_LSQB  = 8'h5B;
	localparam logic [7:0] CH_RSQB  = 8'h5D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_T = 8'h74;
	localparam logic [7:0] CH_LOW_R = 8'h72;
	localparam logic [7:0] CH_LOW_U = 8'h75;
	localparam logic [7:0] CH_LOW_E = 8'h65;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_L = 8'h6C;
	localparam logic [7:0] CH_LOW_S = 8'h73;
	localparam logic [7:0] CH_LOW_N = 8'h6E;

	// Keyword selectors
	localparam logic [1:0] KW_TRUE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;

	// Output queue geometry
	localparam int JST_Q_DEPTH = 4;
	localparam int JST_Q_CW    = 3;

	typedef enum logic [3:0] {
		KIND_LCUB   = 4'd0,
		KIND_RCUB   = 4'd1,
		KIND_LSQB   = 4'd2,
		KIND_RSQB   = 4'd3,
		KIND_COMMA  = 4'd4,
		KIND_COLON  = 4'd5,
		KIND_STRING = 4'd6,
		KIND_NUMBER = 4'd7,
		KIND_TRUE   = 4'd8,
		KIND_FALSE  = 4'd9,
		KIND_NULL   = 4'd10,
		KIND_WHITE  = 4'd11
	} jst_kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_UNEXP    = 3'd1,
		ST_BAD_KW   = 3'd2,
		ST_UNTERM   = 3'd3,
		ST_TOO_DEEP = 3'd4,
		ST_MISMATCH = 3'd5
	} jst_status_t;

	// Scan mode, one-hot
	typedef enum logic [5:0] {
		MODE_IDLE  = 6'b000001,
		MODE_WHITE = 6'b000010,
		MODE_STRV  = 6'b000100,
		MODE_STRK  = 6'b001000,
		MODE_NUM   = 6'b010000,
		MODE_KW    = 6'b100000
	} jst_mode_t;

	// Grammar expectation, one-hot
	typedef enum logic [7:0] {
		EXP_TOP       = 8'b00000001,
		EXP_VALUE     = 8'b00000010,
		EXP_VAL_CLOSE = 8'b00000100,
		EXP_KEY_CLOSE = 8'b00001000,
		EXP_KEY       = 8'b00010000,
		EXP_COLON     = 8'b00100000,
		EXP_AFTER     = 8'b01000000,
		EXP_DONE      = 8'b10000000
	} jst_expect_t;

	typedef struct packed {
		jst_mode_t   mode;
		logic [1:0]  kw_which;
		logic [2:0]  kw_index;
		jst_expect_t expect_st;
		logic        err_latched;
	} jst_scan_t;

	localparam jst_scan_t JST_SCAN_RST = '{
		mode:        MODE_IDLE,
		kw_which:    2'd0,
		kw_index:    3'd0,
		expect_st:   EXP_TOP,
		err_latched: 1'b0
	};

	typedef struct packed {
		jst_kind_t   kind;
		logic [15:0] start_pos;
		logic [15:0] end_pos;
		jst_status_t status;
		logic        last;
	} jst_result_t;

	typedef struct packed {
		logic en;
		logic kind;   // 0 object, 1 array
	} jst_push_t;

	// Keyword spelling, one character per index
	function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [2:0] i);
		logic [7:0] c;
		c = 8'h00;
		unique case (w)
			KW_TRUE: begin
				unique case (i)
					3'd0: c = CH_LOW_T;
					3'd1: c = CH_LOW_R;
					3'd2: c = CH_LOW_U;
					3'd3: c = CH_LOW_E;
					default: c = 8'h00;
				endcase
			end
			KW_FALSE: begin
				unique case (i)
					3'd0: c = CH_LOW_F;
					3'd1: c = CH_LOW_A;
					3'd2: c = CH_LOW_L;
					3'd3: c = CH_LOW_S;
					3'd4: c = CH_LOW_E;
					default: c = 8'h00;
				endcase
			end
			default: begin
				unique case (i)
					3'd0: c = CH_LOW_N;
					3'd1: c = CH_LOW_U;
					3'd2: c = CH_LOW_L;
					3'd3: c = CH_LOW_L;
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] w);
		return (w == KW_FALSE) ? 3'd5 : 3'd4;
	endfunction

endpackage

FILE: hw/rtl/jst_ram.sv
// jst_ram: generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module jst_ram #(
	parameter  int WIDTH = 1,
	parameter  int DEPTH = 32,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/jst_step.sv
// jst_step: per-byte tokenizer logic (scan mode, keyword match, grammar, result build).
// Purely combinational; state registers live in the top level.
// Depends on jst_pkg.
module jst_step #(
	parameter  int MAX_NEST = 32,
	parameter  int POS_BITS = 16,
	localparam int DW       = $clog2(MAX_NEST + 1)
) (
	input  jst_pkg::jst_scan_t   st,
	input  logic [POS_BITS-1:0]  pos,
	input  logic [POS_BITS-1:0]  tstart,
	input  logic [DW-1:0]        depth,
	input  logic                 top_kind,
	input  logic [7:0]           text_byte,
	input  logic                 final_byte,
	output jst_pkg::jst_scan_t   st_n,
	output logic [POS_BITS-1:0]  pos_n,
	output logic [POS_BITS-1:0]  tstart_n,
	output logic [DW-1:0]        depth_n,
	output jst_pkg::jst_push_t   push,
	output logic [1:0]           res_cnt,
	output jst_pkg::jst_result_t res0,
	output jst_pkg::jst_result_t res1
);

	localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NEST);

	function automatic jst_pkg::jst_result_t mk(input jst_pkg::jst_kind_t k,
			input logic [POS_BITS-1:0] s, input logic [POS_BITS-1:0] e,
			input jst_pkg::jst_status_t sc);
		jst_pkg::jst_result_t r;
		r.kind      = k;
		r.start_pos = 16'(s);
		r.end_pos   = 16'(e);
		r.status    = sc;
		r.last      = 1'b0;
		return r;
	endfunction

	logic b_ws, b_digit, b_numc;

	assign b_ws    = (text_byte == jst_pkg::CH_SPACE) || (text_byte == jst_pkg::CH_LF);
	assign b_digit = (text_byte >= jst_pkg::CH_ZERO) && (text_byte <= jst_pkg::CH_NINE);
	assign b_numc  = b_digit || (text_byte == jst_pkg::CH_MINUS) || (text_byte == jst_pkg::CH_DOT);

	always_comb begin
		logic [POS_BITS-1:0]  pos_end;
		logic                 done;
		logic                 val_ok;
		logic                 fin_bad;
		logic                 want;
		logic                 t1_v, t2_v, t3_v, tb_v;
		logic [1:0]           w;
		logic [2:0]           klen;
		jst_pkg::jst_expect_t x;
		jst_pkg::jst_status_t err;
		jst_pkg::jst_result_t tok1, tok2, tok3, tokb, etok;

		pos_end  = pos + POS_BITS'(1);
		st_n     = st;
		pos_n    = pos_end;
		tstart_n = tstart;
		depth_n  = depth;
		push     = '0;
		res_cnt  = 2'd0;
		res0     = '0;
		res1     = '0;
		done     = 1'b0;
		fin_bad  = 1'b0;
		want     = 1'b0;
		t1_v     = 1'b0;
		t2_v     = 1'b0;
		t3_v     = 1'b0;
		tok1     = '0;
		tok2     = '0;
		tok3     = '0;
		err      = jst_pkg::ST_OK;
		w        = (st.kw_which > jst_pkg::KW_NULL) ? jst_pkg::KW_NULL : st.kw_which;
		klen     = jst_pkg::kw_len(w);

		// Continue or close the pending run
		unique case (st.mode)
			jst_pkg::MODE_STRV, jst_pkg::MODE_STRK: begin
				done = 1'b1;
				if (text_byte == jst_pkg::CH_QUOTE) begin
					t1_v = 1'b1;
					tok1 = mk(jst_pkg::KIND_STRING, tstart, pos_end, jst_pkg::ST_OK);
					if (st.mode == jst_pkg::MODE_STRK) begin
						st_n.expect_st = jst_pkg::EXP_COLON;
					end else begin
						st_n.expect_st = (depth != '0) ? jst_pkg::EXP_AFTER : jst_pkg::EXP_DONE;
					end
					st_n.mode = jst_pkg::MODE_IDLE;
				end
			end
			jst_pkg::MODE_KW: begin
				done = 1'b1;
				if ((st.kw_index < klen) && (text_byte == jst_pkg::kw_char(w, st.kw_index))) begin
					st_n.kw_index = st.kw_index + 3'd1;
					if ((st.kw_index + 3'd1) >= klen) begin
						t1_v = 1'b1;
						tok1 = mk(jst_pkg::jst_kind_t'(4'(jst_pkg::KIND_TRUE) + 4'(w)),
							tstart, pos_end, jst_pkg::ST_OK);
						st_n.mode      = jst_pkg::MODE_IDLE;
						st_n.expect_st = (depth != '0) ? jst_pkg::EXP_AFTER : jst_pkg::EXP_DONE;
					end
				end else begin
					err = jst_pkg::ST_BAD_KW;
				end
			end
			jst_pkg::MODE_WHITE: begin
				if (b_ws) begin
					done = 1'b1;
				end else begin
					t1_v      = 1'b1;
					tok1      = mk(jst_pkg::KIND_WHITE, tstart, pos, jst_pkg::ST_OK);
					st_n.mode = jst_pkg::MODE_IDLE;
				end
			end
			jst_pkg::MODE_NUM: begin
				if (b_numc) begin
					done = 1'b1;
				end else begin
					t1_v           = 1'b1;
					tok1           = mk(jst_pkg::KIND_NUMBER, tstart, pos, jst_pkg::ST_OK);
					st_n.mode      = jst_pkg::MODE_IDLE;
					st_n.expect_st = (depth != '0) ? jst_pkg::EXP_AFTER : jst_pkg::EXP_DONE;
				end
			end
			default: begin
				st_n.mode = jst_pkg::MODE_IDLE;
			end
		endcase

		// Byte seen between tokens
		x      = st_n.expect_st;
		val_ok = (x == jst_pkg::EXP_TOP) || (x == jst_pkg::EXP_VALUE) ||
			(x == jst_pkg::EXP_VAL_CLOSE);
		if (!done && (err == jst_pkg::ST_OK)) begin
			priority if (b_ws) begin
				st_n.mode = jst_pkg::MODE_WHITE;
				tstart_n  = pos;
			end else if ((text_byte == jst_pkg::CH_LCUB) || (text_byte == jst_pkg::CH_LSQB)) begin
				want = (text_byte == jst_pkg::CH_LSQB);
				if (!val_ok) begin
					err = jst_pkg::ST_UNEXP;
				end else if (depth_n >= DEPTH_MAX) begin
					err = jst_pkg::ST_TOO_DEEP;
				end else begin
					push.en        = 1'b1;
					push.kind      = want;
					depth_n        = depth_n + DW'(1);
					t2_v           = 1'b1;
					tok2           = mk(want ? jst_pkg::KIND_LSQB : jst_pkg::KIND_LCUB,
						pos, pos_end, jst_pkg::ST_OK);
					st_n.expect_st = want ? jst_pkg::EXP_VAL_CLOSE : jst_pkg::EXP_KEY_CLOSE;
				end
			end else if ((text_byte == jst_pkg::CH_RCUB) || (text_byte == jst_pkg::CH_RSQB)) begin
				want = (text_byte == jst_pkg::CH_RSQB);
				if (!((x == jst_pkg::EXP_AFTER) || (x == jst_pkg::EXP_VAL_CLOSE) ||
						(x == jst_pkg::EXP_KEY_CLOSE)) || (depth_n == '0)) begin
					err = jst_pkg::ST_UNEXP;
				end else if (top_kind != want) begin
					err = jst_pkg::ST_MISMATCH;
				end else begin
					depth_n        = depth_n - DW'(1);
					t2_v           = 1'b1;
					tok2           = mk(want ? jst_pkg::KIND_RSQB : jst_pkg::KIND_RCUB,
						pos, pos_end, jst_pkg::ST_OK);
					st_n.expect_st = (depth_n != '0) ? jst_pkg::EXP_AFTER : jst_pkg::EXP_DONE;
				end
			end else if (text_byte == jst_pkg::CH_COMMA) begin
				if ((x != jst_pkg::EXP_AFTER) || (depth_n == '0)) begin
					err = jst_pkg::ST_UNEXP;
				end else begin
					t2_v           = 1'b1;
					tok2           = mk(jst_pkg::KIND_COMMA, pos, pos_end, jst_pkg::ST_OK);
					st_n.expect_st = top_kind ? jst_pkg::EXP_VALUE : jst_pkg::EXP_KEY;
				end
			end else if (text_byte == jst_pkg::CH_COLON) begin
				if (x != jst_pkg::EXP_COLON) begin
					err = jst_pkg::ST_UNEXP;
				end else begin
					t2_v           = 1'b1;
					tok2           = mk(jst_pkg::KIND_COLON, pos, pos_end, jst_pkg::ST_OK);
					st_n.expect_st = jst_pkg::EXP_VALUE;
				end
			end else if (text_byte == jst_pkg::CH_QUOTE) begin
				if (val_ok) begin
					st_n.mode = jst_pkg::MODE_STRV;
					tstart_n  = pos;
				end else if ((x == jst_pkg::EXP_KEY_CLOSE) || (x == jst_pkg::EXP_KEY)) begin
					st_n.mode = jst_pkg::MODE_STRK;
					tstart_n  = pos;
				end else begin
					err = jst_pkg::ST_UNEXP;
				end
			end else if ((text_byte == jst_pkg::CH_MINUS) || b_digit) begin
				if (!val_ok) begin
					err = jst_pkg::ST_UNEXP;
				end else begin
					st_n.mode = jst_pkg::MODE_NUM;
					tstart_n  = pos;
				end
			end else if ((text_byte == jst_pkg::CH_LOW_T) || (text_byte == jst_pkg::CH_LOW_F) ||
					(text_byte == jst_pkg::CH_LOW_N)) begin
				if (!val_ok) begin
					err = jst_pkg::ST_UNEXP;
				end else begin
					st_n.mode     = jst_pkg::MODE_KW;
					tstart_n      = pos;
					st_n.kw_index = 3'd1;
					st_n.kw_which = (text_byte == jst_pkg::CH_LOW_T) ? jst_pkg::KW_TRUE :
						((text_byte == jst_pkg::CH_LOW_F) ? jst_pkg::KW_FALSE : jst_pkg::KW_NULL);
				end
			end else begin
				err = jst_pkg::ST_UNEXP;
			end
		end

		// End of text: flush an open run, check for unfinished structure
		if ((err == jst_pkg::ST_OK) && final_byte) begin
			if ((st_n.mode == jst_pkg::MODE_STRV) || (st_n.mode == jst_pkg::MODE_STRK) ||
					(st_n.mode == jst_pkg::MODE_KW)) begin
				fin_bad = 1'b1;
			end else if (st_n.mode == jst_pkg::MODE_WHITE) begin
				t3_v = 1'b1;
				tok3 = mk(jst_pkg::KIND_WHITE, tstart_n, pos_end, jst_pkg::ST_OK);
			end else if (st_n.mode == jst_pkg::MODE_NUM) begin
				t3_v           = 1'b1;
				tok3           = mk(jst_pkg::KIND_NUMBER, tstart_n, pos_end, jst_pkg::ST_OK);
				st_n.expect_st = (depth_n != '0) ? jst_pkg::EXP_AFTER : jst_pkg::EXP_DONE;
			end
			if ((st_n.expect_st != jst_pkg::EXP_TOP) && (st_n.expect_st != jst_pkg::EXP_DONE)) begin
				fin_bad = 1'b1;
			end
		end

		if (err != jst_pkg::ST_OK) begin
			st_n.err_latched = 1'b1;
			push             = '0;
		end

		// Result assembly: pending-run token first, then own token or error
		etok = mk(jst_pkg::KIND_LCUB, pos, pos_end, fin_bad ? jst_pkg::ST_UNTERM : err);
		tb_v = t2_v || t3_v;
		tokb = t2_v ? tok2 : tok3;
		if (st.err_latched) begin
			res_cnt = 2'd0;
			st_n    = st;
			depth_n = depth;
			tstart_n = tstart;
			push    = '0;
		end else if ((err != jst_pkg::ST_OK) || fin_bad) begin
			res0    = t1_v ? tok1 : etok;
			res1    = etok;
			res_cnt = t1_v ? 2'd2 : 2'd1;
		end else if (t1_v) begin
			res0    = tok1;
			res1    = tokb;
			res_cnt = tb_v ? 2'd2 : 2'd1;
		end else begin
			res0    = tokb;
			res1    = tokb;
			res_cnt = tb_v ? 2'd1 : 2'd0;
		end
		res0.last = (res_cnt == 2'd1);
		res1.last = 1'b1;

		// Final byte returns everything to the reset state
		if (final_byte) begin
			st_n     = jst_pkg::JST_SCAN_RST;
			pos_n    = '0;
			tstart_n = '0;
			depth_n  = '0;
		end
	end

endmodule

FILE: hw/rtl/jst_outq.sv
// jst_outq: four-entry result queue; takes up to two results per cycle, gives one.
// Separates the tokenizer from the output stall. Depends on jst_pkg.
module jst_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [1:0]                   wr_cnt,
	input  jst_pkg::jst_result_t         wr0,
	input  jst_pkg::jst_result_t         wr1,
	input  logic                         rd,
	output jst_pkg::jst_result_t         rd_data,
	output logic [jst_pkg::JST_Q_CW-1:0] cnt
);

	localparam int PW = $clog2(jst_pkg::JST_Q_DEPTH);

	jst_pkg::jst_result_t entry_q [jst_pkg::JST_Q_DEPTH];
	logic [PW-1:0]                 wp_q;
	logic [PW-1:0]                 rp_q;
	logic [jst_pkg::JST_Q_CW-1:0]  cnt_q;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(wr_cnt);
			rp_q  <= rp_q + PW'(rd);
			cnt_q <= cnt_q + jst_pkg::JST_Q_CW'(wr_cnt) - jst_pkg::JST_Q_CW'(rd);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			entry_q[wp_q] <= wr0;
		end
		if (wr_cnt == 2'd2) begin
			entry_q[PW'(wp_q + PW'(1))] <= wr1;
		end
	end

	assign rd_data = entry_q[rp_q];
	assign cnt     = cnt_q;

endmodule

FILE: hw/rtl/json_stream_tokenizer.sv
// json_stream_tokenizer: top level of the streaming JSON tokenizer.
// Holds the scan state registers and ties together jst_step, jst_ram and jst_outq.
// Depends on jst_pkg, jst_step, jst_ram, jst_outq.

// One text byte is accepted per clock while in_stall is low. Each byte is scanned against
// the current state and yields zero, one or two results (kind, start and end position,
// status, last-of-byte flag), which enter a four-entry result queue and appear on the
// output no earlier than the cycle after the byte. The queue hands out one result per
// clock while out_stall is low, so the input runs at one byte per cycle whenever the bytes
// average at most one result; the input stalls while three or more results are queued.
// The bracket stack is a MAX_NEST x 1 RAM with a registered read whose address tracks
// the next depth, so the innermost container kind is ready for the following byte; the
// stack needs no clearing pass since only entries below the current depth are read.
// After an error one error result is given and bytes produce nothing until the final
// byte, which, like every final byte, returns the block to its reset state.
module json_stream_tokenizer #(
	parameter int MAX_NEST = 32,
	parameter int POS_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  token_kind,
	output logic [15:0] start_pos,
	output logic [15:0] end_pos,
	output logic [2:0]  status,
	output logic        run_last
);

	localparam int DW = $clog2(MAX_NEST + 1);
	localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

	jst_pkg::jst_scan_t           st_q, st_n;
	logic [POS_BITS-1:0]          pos_q, pos_n;
	logic [POS_BITS-1:0]          tstart_q, tstart_n;
	logic [DW-1:0]                depth_q, depth_n, depth_next;
	jst_pkg::jst_push_t           push;
	logic [1:0]                   res_cnt;
	jst_pkg::jst_result_t         res0, res1, q_head;
	logic [jst_pkg::JST_Q_CW-1:0] q_cnt;
	logic                         in_accept, out_accept;
	logic                         stack_we;
	logic [AW-1:0]                stack_raddr;
	logic                         stack_rdata;
	logic                         byp_q, byp_kind_q;
	logic                         top_kind;

	assign in_stall   = (q_cnt >= jst_pkg::JST_Q_CW'(3));
	assign in_accept  = in_valid && !in_stall;
	assign out_valid  = (q_cnt != '0);
	assign out_accept = out_valid && !out_stall;

	// Per-byte tokenizer logic
	jst_step #(
		.MAX_NEST (MAX_NEST),
		.POS_BITS (POS_BITS)
	) u_step (
		.st         (st_q),
		.pos        (pos_q),
		.tstart     (tstart_q),
		.depth      (depth_q),
		.top_kind   (top_kind),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.st_n       (st_n),
		.pos_n      (pos_n),
		.tstart_n   (tstart_n),
		.depth_n    (depth_n),
		.push       (push),
		.res_cnt    (res_cnt),
		.res0       (res0),
		.res1       (res1)
	);

	// Scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= jst_pkg::JST_SCAN_RST;
			pos_q    <= '0;
			tstart_q <= '0;
			depth_q  <= '0;
		end else if (in_accept) begin
			st_q     <= st_n;
			pos_q    <= pos_n;
			tstart_q <= tstart_n;
			depth_q  <= depth_n;
		end
	end

	// Bracket stack: read the entry that will be on top after this cycle
	assign depth_next  = in_accept ? depth_n : depth_q;
	assign stack_raddr = AW'(depth_next - DW'(1));
	assign stack_we    = in_accept && push.en;

	jst_ram #(
		.WIDTH (1),
		.DEPTH (MAX_NEST)
	) u_stack (
		.clk   (clk),
		.we    (stack_we),
		.waddr (depth_q[AW-1:0]),
		.wdata (push.kind),
		.raddr (stack_raddr),
		.rdata (stack_rdata)
	);

	// Bypass the entry written last cycle (RAM reads old data on collision)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= stack_we;
		end
	end

	always_ff @(posedge clk) begin
		byp_kind_q <= push.kind;
	end

	assign top_kind = byp_q ? byp_kind_q : stack_rdata;

	// Result queue
	jst_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_cnt  (in_accept ? res_cnt : 2'd0),
		.wr0     (res0),
		.wr1     (res1),
		.rd      (out_accept),
		.rd_data (q_head),
		.cnt     (q_cnt)
	);

	assign token_kind = q_head.kind;
	assign start_pos  = q_head.start_pos;
	assign end_pos    = q_head.end_pos;
	assign status     = q_head.status;
	assign run_last   = q_head.last;

	// Checks
	a_push_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		stack_we |-> (depth_q < DW'(MAX_NEST)))
		else $error("stack push beyond capacity");

	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && final_byte) |=> ((depth_q == '0) && (pos_q == '0) && !st_q.err_latched))
		else $error("final byte did not return the block to reset state");

	a_silent_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && st_q.err_latched) |-> (res_cnt == 2'd0))
		else $error("result produced after an error");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt <= jst_pkg::JST_Q_CW'(jst_pkg::JST_Q_DEPTH))
		else $error("result queue overflow");

endmodule
